### rtl/hsv_pkg.sv
// Shared types and fixed-point constants for the HSV to RGB converter.
`default_nettype none

package hsv_pkg;

   localparam int HUE_WIDTH  = 16;
   localparam int UNIT_WIDTH = 8;

   typedef logic [HUE_WIDTH-1:0]  hue_type;
   typedef logic [UNIT_WIDTH-1:0] unit_type;

   // One full unit of hue fraction and of 8-bit intensity.
   localparam logic [16:0] FRAC_ONE  = 17'h10000;
   localparam logic [7:0]  UNIT_MAX  = 8'd255;
   localparam logic [15:0] UNIT_HALF = 16'd127;

   // Joint denominator 255 * 65536 and its half, for round half up.
   localparam logic [23:0] DEN_FULL = 24'd16711680;
   localparam logic [31:0] DEN_HALF = 32'd8355840;

   // Exact reciprocal of 255 for any 16-bit dividend: (x * 0x8081) >> 23.
   localparam logic [15:0] RECIP_255   = 16'h8081;
   localparam int          RECIP_SHIFT = 23;

   // Sixth of the hue circle that the color falls in.
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

endpackage

`default_nettype wire

### rtl/hsv_req_if.sv
// Input channel carrying one HSV color per item.
`default_nettype none

interface hsv_req_if;
   logic              valid;
   logic              ready;
   hsv_pkg::hue_type  hue;
   hsv_pkg::unit_type saturation;
   hsv_pkg::unit_type brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

`default_nettype wire

### rtl/hsv_rsp_if.sv
// Result channel carrying one RGB color per item.
`default_nettype none

interface hsv_rsp_if;
   logic              valid;
   logic              ready;
   hsv_pkg::unit_type red;
   hsv_pkg::unit_type green;
   hsv_pkg::unit_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### rtl/hsv_to_rgb_converter.sv
// HSV to RGB color converter: five-stage pipeline with valid/ready handshakes.
//
// Usage: each item on req_port carries hue (unsigned Q0.16 fraction of a turn),
// saturation and brightness (8-bit fractions, 255 is 1.0). Each accepted item
// produces exactly one item on rsp_port with red, green and blue rounded to 8 bits.
// Items leave in the order they arrived.
//
// Results are registered in stages one to five. Throughput is one item per clock
// while rsp_port.ready stays high: every stage holds a valid bit that travels
// with its data, so a new item can enter in every cycle. The depth is set by
// the multiply chain: hue times six, saturation times fraction, brightness times
// the complement, then an exact reciprocal multiply that divides by 255.
//
// When the receiver stalls, the result stays in the output register and each
// stage keeps its item; empty stages still fill, so up to five items are held
// before req_port.ready drops. Nothing is lost or repeated.
//
// Reset is synchronous and active high. It clears every valid bit, so the
// pipeline comes up empty and ready to accept an item in the next cycle.
`default_nettype none

module hsv_to_rgb_converter (
   input  wire        clock,
   input  wire        reset,
   hsv_req_if.sink    req_port,
   hsv_rsp_if.source  rsp_port
);

   // Stage 1: sector and hue fraction from hue times six.
   logic                 s1_valid_ff;
   hsv_pkg::sector_type  s1_sector_ff, s1_sector_in;
   logic [15:0]          s1_frac_ff, s1_frac_in;
   hsv_pkg::unit_type    s1_sat_ff, s1_val_ff;
   logic [18:0]          hue_x6;

   // Stage 2: saturation products.
   logic                 s2_valid_ff;
   hsv_pkg::sector_type  s2_sector_ff;
   hsv_pkg::unit_type    s2_val_ff;
   logic                 s2_grey_ff;
   logic [23:0]          s2_sf_ff, s2_sf_in;
   logic [23:0]          s2_sg_ff, s2_sg_in;
   logic [15:0]          s2_pprod_ff, s2_pprod_in;
   logic [16:0]          frac_comp;

   // Stage 3: brightness times the complements.
   logic                 s3_valid_ff;
   hsv_pkg::sector_type  s3_sector_ff;
   hsv_pkg::unit_type    s3_val_ff;
   logic                 s3_grey_ff;
   logic [31:0]          s3_qprod_ff, s3_qprod_in;
   logic [31:0]          s3_tprod_ff, s3_tprod_in;
   logic [15:0]          s3_pnum_ff, s3_pnum_in;

   // Stage 4: rounding and reciprocal multiply by 1/255.
   logic                 s4_valid_ff;
   hsv_pkg::sector_type  s4_sector_ff;
   hsv_pkg::unit_type    s4_val_ff;
   logic                 s4_grey_ff;
   logic [31:0]          s4_qmul_ff, s4_qmul_in;
   logic [31:0]          s4_tmul_ff, s4_tmul_in;
   logic [31:0]          s4_pmul_ff, s4_pmul_in;
   logic [31:0]          qsum, tsum;

   // Stage 5: sector mapping into the output register.
   logic                 out_valid_ff;
   hsv_pkg::unit_type    out_red_ff, out_red_in;
   hsv_pkg::unit_type    out_green_ff, out_green_in;
   hsv_pkg::unit_type    out_blue_ff, out_blue_in;
   hsv_pkg::unit_type    out_val_ff;
   hsv_pkg::unit_type    p_chan, q_chan, t_chan;

   // A stage takes new data when it is empty or its item moves on.
   logic out_ready, s4_ready, s3_ready, s2_ready, s1_ready;

   assign out_ready = !out_valid_ff || rsp_port.ready;
   assign s4_ready  = !s4_valid_ff  || out_ready;
   assign s3_ready  = !s3_valid_ff  || s4_ready;
   assign s2_ready  = !s2_valid_ff  || s3_ready;
   assign s1_ready  = !s1_valid_ff  || s2_ready;

   assign req_port.ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_port.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s4_valid_ff;
         end
      end
   end

   // Stage 1. Hue times six is two shifted adds; the top three bits are the
   // sector and the low sixteen the position inside it.
   assign hue_x6       = ({3'b000, req_port.hue} << 2) + ({3'b000, req_port.hue} << 1);
   assign s1_sector_in = hsv_pkg::sector_type'(hue_x6[18:16]);
   assign s1_frac_in   = hue_x6[15:0];

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_sector_ff <= s1_sector_in;
         s1_frac_ff   <= s1_frac_in;
         s1_sat_ff    <= req_port.saturation;
         s1_val_ff    <= req_port.brightness;
      end
   end

   // Stage 2. S*f for q, S*(1-f) for t and V*(1-S) for p. S*(1-f) never
   // exceeds the joint denominator, so 24 bits hold it.
   assign frac_comp   = hsv_pkg::FRAC_ONE - {1'b0, s1_frac_ff};
   assign s2_sf_in    = 24'(s1_sat_ff * s1_frac_ff);
   assign s2_sg_in    = 24'(s1_sat_ff * frac_comp);
   assign s2_pprod_in = 16'(s1_val_ff * (hsv_pkg::UNIT_MAX - s1_sat_ff));

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_sector_ff <= s1_sector_ff;
         s2_val_ff    <= s1_val_ff;
         s2_grey_ff   <= (s1_sat_ff == '0);
         s2_sf_ff     <= s2_sf_in;
         s2_sg_ff     <= s2_sg_in;
         s2_pprod_ff  <= s2_pprod_in;
      end
   end

   // Stage 3. The numerators before rounding stay below 2^32.
   assign s3_qprod_in = 32'(s2_val_ff * (hsv_pkg::DEN_FULL - s2_sf_ff));
   assign s3_tprod_in = 32'(s2_val_ff * (hsv_pkg::DEN_FULL - s2_sg_ff));
   assign s3_pnum_in  = s2_pprod_ff + hsv_pkg::UNIT_HALF;

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_sector_ff <= s2_sector_ff;
         s3_val_ff    <= s2_val_ff;
         s3_grey_ff   <= s2_grey_ff;
         s3_qprod_ff  <= s3_qprod_in;
         s3_tprod_ff  <= s3_tprod_in;
         s3_pnum_ff   <= s3_pnum_in;
      end
   end

   // Stage 4. Dividing by 255 * 65536 is a 16-bit shift followed by an
   // exact divide by 255 done as a reciprocal multiply.
   assign qsum       = s3_qprod_ff + hsv_pkg::DEN_HALF;
   assign tsum       = s3_tprod_ff + hsv_pkg::DEN_HALF;
   assign s4_qmul_in = qsum[31:16] * hsv_pkg::RECIP_255;
   assign s4_tmul_in = tsum[31:16] * hsv_pkg::RECIP_255;
   assign s4_pmul_in = s3_pnum_ff * hsv_pkg::RECIP_255;

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_sector_ff <= s3_sector_ff;
         s4_val_ff    <= s3_val_ff;
         s4_grey_ff   <= s3_grey_ff;
         s4_qmul_ff   <= s4_qmul_in;
         s4_tmul_ff   <= s4_tmul_in;
         s4_pmul_ff   <= s4_pmul_in;
      end
   end

   // Stage 5. Quotients never exceed 255, so eight bits above the shift hold them.
   assign p_chan = s4_pmul_ff[hsv_pkg::RECIP_SHIFT +: 8];
   assign q_chan = s4_qmul_ff[hsv_pkg::RECIP_SHIFT +: 8];
   assign t_chan = s4_tmul_ff[hsv_pkg::RECIP_SHIFT +: 8];

   always_comb begin
      out_red_in   = s4_val_ff;
      out_green_in = s4_val_ff;
      out_blue_in  = s4_val_ff;
      if (!s4_grey_ff) begin
         unique case (s4_sector_ff)
            hsv_pkg::SECTOR_RED_YELLOW: begin
               out_red_in = s4_val_ff; out_green_in = t_chan; out_blue_in = p_chan;
            end
            hsv_pkg::SECTOR_YELLOW_GREEN: begin
               out_red_in = q_chan; out_green_in = s4_val_ff; out_blue_in = p_chan;
            end
            hsv_pkg::SECTOR_GREEN_CYAN: begin
               out_red_in = p_chan; out_green_in = s4_val_ff; out_blue_in = t_chan;
            end
            hsv_pkg::SECTOR_CYAN_BLUE: begin
               out_red_in = p_chan; out_green_in = q_chan; out_blue_in = s4_val_ff;
            end
            hsv_pkg::SECTOR_BLUE_MAGENTA: begin
               out_red_in = t_chan; out_green_in = p_chan; out_blue_in = s4_val_ff;
            end
            default: begin
               out_red_in = s4_val_ff; out_green_in = p_chan; out_blue_in = q_chan;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_red_ff   <= out_red_in;
         out_green_ff <= out_green_in;
         out_blue_ff  <= out_blue_in;
         out_val_ff   <= s4_val_ff;
      end
   end

   assign rsp_port.valid = out_valid_ff;
   assign rsp_port.red   = out_red_ff;
   assign rsp_port.green = out_green_ff;
   assign rsp_port.blue  = out_blue_ff;

   // The pipeline comes out of reset empty.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_port.valid)
      else $error("result valid right after reset");

   // The sector mapping always routes brightness to at least one channel.
   a_value_routed: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_red_ff == out_val_ff) || (out_green_ff == out_val_ff)
                       || (out_blue_ff == out_val_ff))
      else $error("no channel carries the brightness");

   // p, q and t never exceed brightness.
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_red_ff <= out_val_ff) && (out_green_ff <= out_val_ff)
                       && (out_blue_ff <= out_val_ff))
      else $error("channel above brightness");

   // Stage four, when stalled, never drops its item.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && !out_ready) |=> s4_valid_ff)
      else $error("stage four lost an item under stall");

endmodule

`default_nettype wire

### dv/hsv_color_checker.sv
// Checker for the HSV to RGB converter: predicts each color and compares the results.
module hsv_color_checker (
   input  logic       clock,
   input  logic       reset,
   hsv_req_if         req_mon,
   hsv_rsp_if         rsp_mon,
   output int         mismatch_count,
   output int         pending_count
);

   typedef struct packed {
      hsv_pkg::unit_type red;
      hsv_pkg::unit_type green;
      hsv_pkg::unit_type blue;
   } rgb_color_type;

   // Joint denominator of the q and t terms: 255 levels times a Q0.16 unit.
   localparam longint unsigned JOINT_SPAN = 64'd255 * 64'd65536;

   rgb_color_type expected_colors[$];
   int            mismatches = 0;

   function automatic rgb_color_type convert_hsv(hsv_pkg::hue_type hue,
                                                 hsv_pkg::unit_type sat,
                                                 hsv_pkg::unit_type val);
      logic [18:0]         hue6;
      logic [15:0]         frac;
      hsv_pkg::sector_type sector;
      longint unsigned     vv;
      longint unsigned     ss;
      longint unsigned     ff;
      hsv_pkg::unit_type   p;
      hsv_pkg::unit_type   q;
      hsv_pkg::unit_type   t;
      rgb_color_type       color;
      hue6   = 19'(hue) * 19'd6;
      sector = hsv_pkg::sector_type'(hue6[18:16]);
      frac   = hue6[15:0];
      vv     = val;
      ss     = sat;
      ff     = frac;
      p = hsv_pkg::unit_type'((vv * (64'd255 - ss) + 64'd127) / 64'd255);
      q = hsv_pkg::unit_type'((vv * (JOINT_SPAN - ss * ff) + JOINT_SPAN / 2) / JOINT_SPAN);
      t = hsv_pkg::unit_type'((vv * (JOINT_SPAN - ss * (64'd65536 - ff)) + JOINT_SPAN / 2)
                              / JOINT_SPAN);
      if (sat == '0) begin
         color = '{val, val, val};
      end else begin
         case (sector)
            hsv_pkg::SECTOR_RED_YELLOW:   color = '{val, t, p};
            hsv_pkg::SECTOR_YELLOW_GREEN: color = '{q, val, p};
            hsv_pkg::SECTOR_GREEN_CYAN:   color = '{p, val, t};
            hsv_pkg::SECTOR_CYAN_BLUE:    color = '{p, q, val};
            hsv_pkg::SECTOR_BLUE_MAGENTA: color = '{t, p, val};
            default:                      color = '{val, p, q};
         endcase
      end
      return color;
   endfunction

   // Results are checked before new items are queued, so a result can never
   // be matched against the item accepted at the same edge.
   always @(posedge clock) begin
      rgb_color_type oldest;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_colors.size() == 0) begin
               $error("unexpected result: red %0d green %0d blue %0d",
                      rsp_mon.red, rsp_mon.green, rsp_mon.blue);
               mismatches++;
            end else begin
               oldest = expected_colors.pop_front();
               if (rsp_mon.red !== oldest.red) begin
                  $error("red: expected %0d, actual %0d", oldest.red, rsp_mon.red);
                  mismatches++;
               end
               if (rsp_mon.green !== oldest.green) begin
                  $error("green: expected %0d, actual %0d", oldest.green, rsp_mon.green);
                  mismatches++;
               end
               if (rsp_mon.blue !== oldest.blue) begin
                  $error("blue: expected %0d, actual %0d", oldest.blue, rsp_mon.blue);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_colors.insert(expected_colors.size(),
                                   convert_hsv(req_mon.hue, req_mon.saturation,
                                               req_mon.brightness));
         end
      end
      mismatch_count <= mismatches;
      pending_count  <= expected_colors.size();
   end

endmodule

### dv/hsv_to_rgb_converter_tb.sv
// Testbench top for the HSV to RGB converter: clock, reset, stimulus and verdict.
module hsv_to_rgb_converter_tb;

   // Hue steps at which the sector changes (one sixth of a turn each).
   localparam int SECTOR_STEP = 10923;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;

   hsv_req_if req_bus ();
   hsv_rsp_if rsp_bus ();

   hsv_to_rgb_converter i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   hsv_color_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run is bounded by the slowest legal schedule several times over; if
   // it has not ended by then, something hangs.
   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

   // Sends one color. The gap before the item is drawn per item, except in
   // the burst window and in the quiet stretches, where items go back to back.
   // Valid stays high between back-to-back items, so it is never lowered and
   // raised again within one time step.
   task automatic send_color(input hsv_pkg::hue_type hue, input hsv_pkg::unit_type sat,
                             input hsv_pkg::unit_type val, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.hue        <= hue;
      req_bus.saturation <= sat;
      req_bus.brightness <= val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Waits until every expected result has come back. The first edge lets
   // the checker count the item that was accepted at the current edge.
   task automatic drain_results();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Stimulus: a directed set first, then random colors.
   initial begin
      hsv_pkg::hue_type  hue;
      hsv_pkg::unit_type sat;
      hsv_pkg::unit_type val;
      int                pick;
      bit                no_gap;
      req_bus.valid      <= 1'b0;
      req_bus.hue        <= '0;
      req_bus.saturation <= '0;
      req_bus.brightness <= '0;
      reset              <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes and black.
      send_color(16'h0000, 8'h00, 8'h00, 1'b0);
      send_color(16'hFFFF, 8'hFF, 8'hFF, 1'b0);
      send_color(16'h0000, 8'hFF, 8'hFF, 1'b0);
      send_color(16'h0001, 8'h01, 8'h01, 1'b1);
      // The middle of every sector at full saturation and brightness.
      for (int s = 0; s < 6; s++) begin
         send_color(hsv_pkg::hue_type'(SECTOR_STEP / 2 + s * SECTOR_STEP), 8'hFF, 8'hFF,
                    1'b1);
      end
      // Zero saturation gives grey; zero brightness gives black.
      send_color(16'd12345, 8'h00, 8'd200, 1'b0);
      send_color(16'd40000, 8'd200, 8'h00, 1'b0);
      // Hue just below a full turn lands in the last sector.
      send_color(16'hFFFF, 8'd128, 8'd77, 1'b0);
      // Both sides of each sector boundary but the half turn, where only the upper side is sent.
      send_color(16'd10922, 8'hFF, 8'hC0, 1'b1);
      send_color(16'd10923, 8'hFF, 8'hC0, 1'b1);
      send_color(16'd21845, 8'hE0, 8'hFF, 1'b0);
      send_color(16'd21846, 8'hE0, 8'hFF, 1'b0);
      send_color(16'd32768, 8'h80, 8'hFF, 1'b1);
      send_color(16'd43690, 8'hFF, 8'd99, 1'b1);
      send_color(16'd43691, 8'hFF, 8'd99, 1'b0);
      send_color(16'd54613, 8'd33, 8'd250, 1'b0);
      send_color(16'd54614, 8'd33, 8'd250, 1'b1);
      // Alternating bit patterns in every field.
      send_color(16'hAAAA, 8'h55, 8'hAA, 1'b0);
      send_color(16'h5555, 8'hAA, 8'h55, 1'b0);

      for (int i = 0; i < 1030; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            hue = hsv_pkg::hue_type'($urandom_range(0, 65535));
         end else if (pick < 90) begin
            // Close to a sector boundary, where the fraction wraps.
            hue = hsv_pkg::hue_type'($urandom_range(0, 6) * SECTOR_STEP
                                     + $urandom_range(0, 6) - 3);
         end else begin
            hue = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
         end
         pick = $urandom_range(0, 9);
         sat = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF
               : hsv_pkg::unit_type'($urandom_range(0, 255));
         pick = $urandom_range(0, 9);
         val = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF
               : hsv_pkg::unit_type'($urandom_range(0, 255));
         // Items 150 to 399 go back to back so that the receiver's long
         // hold-off fills the pipeline and stalls the input; every fourth
         // hundred also runs without gaps.
         no_gap = (i >= 150 && i < 400) || ((i / 100) % 4 == 3);
         send_color(hue, sat, val, no_gap);
         // Once, the sender stops until the pipeline has fully drained.
         if (i == 500) begin
            req_bus.valid <= 1'b0;
            drain_results();
         end
      end
      req_bus.valid <= 1'b0;

      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Receiver: stalls a random number of cycles before each item, except in
   // quiet stretches. Once, it holds ready low for a long stretch so that the
   // pipeline fills while the sender keeps offering items.
   initial begin
      int          stall;
      int unsigned delivered;
      bit          long_hold_done;
      delivered      = 0;
      long_hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (delivered == 180 && !long_hold_done) begin
            stall          = 120;
            long_hold_done = 1'b1;
         end else if ((delivered / 100) % 3 == 2) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 14);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         delivered++;
      end
   end

endmodule
